>>> rtl/lfr_pkg.sv
// shared types and constants of the led frame receiver
package lfr_pkg;

  localparam logic [7:0] SYNC1_BYTE  = 8'h36;
  localparam logic [7:0] SYNC2_BYTE  = 8'h16;
  localparam logic [7:0] CMD_BYTE    = 8'hA0;
  localparam logic [7:0] TRAIL1_BYTE = 8'h28;
  localparam logic [7:0] TRAIL2_BYTE = 8'h98;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned LED_IDX_W = 5;

  // register index as decoded from paddr[2]
  localparam logic REG_BOARD_ADDR = 1'b0;
  localparam logic REG_RX_TIMEOUT = 1'b1;

  typedef enum logic [8:0] {
    ST_SYNC1  = 9'b000000001,
    ST_SYNC2  = 9'b000000010,
    ST_ADDR   = 9'b000000100,
    ST_CMD    = 9'b000001000,
    ST_DATA   = 9'b000010000,
    ST_TRAIL1 = 9'b000100000,
    ST_TRAIL2 = 9'b001000000,
    ST_RD     = 9'b010000000,
    ST_OUT    = 9'b100000000
  } lfr_state_e;

  typedef struct packed {
    logic rec_tick;
    logic clr_cnt;
    logic wr_byte;
    logic rd_start;
    logic rd_issue;
    logic rd_next;
  } lfr_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic addr_match;
    logic is_cmd;
    logic is_trail1;
    logic is_trail2;
    logic timeout;
    logic payload_last;
    logic rd_last;
  } lfr_sts_t;

endpackage

>>> rtl/led_frame_receiver_top.sv
// top level of the led frame receiver
// Each input transaction carries one received byte and the current tick. The receiver
// hunts for 0x36 0x16 <board address> 0xA0, stores PAYLOAD_BYTES payload bytes and then
// checks the trailer 0x28 0x98; each byte is handled in the cycle of its
// transaction. On a good trailer it stops taking input and sends LEDS_DRIVEN result
// transactions, one per LED, the final one flagged by last_of_frame_o. Each result
// is first read from the payload memory through its registered read port and then
// presented until taken; in_stall_o stays high for the whole burst. A 0x36 byte
// outside the payload, or a nonzero rx_timeout elapsed since the last byte taken in
// the first sync state (32-bit wrapping), restarts the hunt. Registers:
// board_address at 0x0, rx_timeout at 0x4, both reset to zero.
module led_frame_receiver_top
  import lfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 32,
  parameter int unsigned LEDS_DRIVEN   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // byte input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  input  logic [31:0]          now_tick_i,
  // led result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LED_IDX_W-1:0] led_index_o,
  output logic [7:0]           led_state_o,
  output logic                 last_of_frame_o
);

  logic [7:0]  board_addr;
  logic [31:0] rx_timeout;
  lfr_cmd_t    cmd;
  lfr_sts_t    sts;

  // configuration registers
  lfr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .board_addr_o (board_addr),
    .rx_timeout_o (rx_timeout)
  );

  // phase tracking and burst sequencing
  lfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // byte matching, tick compare, payload memory and result registers
  lfr_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .LEDS_DRIVEN   (LEDS_DRIVEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .now_tick_i      (now_tick_i),
    .board_addr_i    (board_addr),
    .rx_timeout_i    (rx_timeout),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .led_index_o     (led_index_o),
    .led_state_o     (led_state_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // input is held off for the whole burst
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input is open");

  // the final result hands control back to the hunt
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_frame_o) |=> !in_stall_o && !out_valid_o)
    else $error("input not reopened after last result");

  // a taken non-final result is followed by the next led index
  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_frame_o) |=>
      !out_valid_o ##1 (out_valid_o && led_index_o == $past(led_index_o, 2) + 5'd1))
    else $error("led index did not advance by one");

endmodule

>>> rtl/lfr_regs.sv
// apb configuration registers of the led frame receiver
module lfr_regs
  import lfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [7:0]         board_addr_o,
  output logic [31:0]        rx_timeout_o
);

  logic [7:0]  board_addr_q;
  logic [31:0] rx_timeout_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_addr_q <= '0;
      rx_timeout_q <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_BOARD_ADDR: board_addr_q <= pwdata[7:0];
        REG_RX_TIMEOUT: rx_timeout_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BOARD_ADDR: prdata = {24'd0, board_addr_q};
      REG_RX_TIMEOUT: prdata = rx_timeout_q;
      default:        prdata = '0;
    endcase
  end

  assign board_addr_o = board_addr_q;
  assign rx_timeout_o = rx_timeout_q;

endmodule

>>> rtl/lfr_ctrl.sv
// frame hunting and result burst controller
module lfr_ctrl
  import lfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_stall_i,
  input  lfr_sts_t sts_i,
  output lfr_cmd_t cmd_o,
  output logic     in_stall_o,
  output logic     out_valid_o
);

  lfr_state_e state_q, state_d, eff;
  logic       hunt;

  assign hunt        = (state_q != ST_RD) && (state_q != ST_OUT);
  assign in_stall_o  = ~hunt;
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    eff     = state_q;
    // sync byte outside payload, or expired timeout, restarts the hunt
    if (sts_i.is_sync1 && state_q != ST_DATA) begin
      eff = ST_SYNC1;
    end else if (sts_i.timeout) begin
      eff = ST_SYNC1;
    end
    if (state_q == ST_RD) begin
      cmd_o.rd_issue = 1'b1;
      state_d        = ST_OUT;
    end else if (state_q == ST_OUT) begin
      if (!out_stall_i) begin
        if (sts_i.rd_last) begin
          state_d = ST_SYNC1;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = ST_RD;
        end
      end
    end else if (in_valid_i) begin
      case (eff)
        ST_SYNC1: begin
          cmd_o.rec_tick = 1'b1;
          state_d = sts_i.is_sync1 ? ST_SYNC2 : ST_SYNC1;
        end
        ST_SYNC2: state_d = sts_i.is_sync2 ? ST_ADDR : ST_SYNC1;
        ST_ADDR:  state_d = sts_i.addr_match ? ST_CMD : ST_SYNC1;
        ST_CMD: begin
          if (sts_i.is_cmd) begin
            cmd_o.clr_cnt = 1'b1;
            state_d = ST_DATA;
          end else begin
            state_d = ST_SYNC1;
          end
        end
        ST_DATA: begin
          cmd_o.wr_byte = 1'b1;
          state_d = sts_i.payload_last ? ST_TRAIL1 : ST_DATA;
        end
        ST_TRAIL1: state_d = sts_i.is_trail1 ? ST_TRAIL2 : ST_SYNC1;
        ST_TRAIL2: begin
          if (sts_i.is_trail2) begin
            cmd_o.rd_start = 1'b1;
            state_d = ST_RD;
          end else begin
            state_d = ST_SYNC1;
          end
        end
        default: state_d = ST_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lfr_dp.sv
// byte compare, timeout, payload store and readout datapath
module lfr_dp
  import lfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 32,
  parameter int unsigned LEDS_DRIVEN   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_byte_i,
  input  logic [31:0]          now_tick_i,
  input  logic [7:0]           board_addr_i,
  input  logic [31:0]          rx_timeout_i,
  input  lfr_cmd_t             cmd_i,
  output lfr_sts_t             sts_o,
  output logic [LED_IDX_W-1:0] led_index_o,
  output logic [7:0]           led_state_o,
  output logic                 last_of_frame_o
);

  localparam int unsigned DEPTH =
    (PAYLOAD_BYTES > LEDS_DRIVEN) ? PAYLOAD_BYTES : LEDS_DRIVEN;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = (LEDS_DRIVEN > 1) ? $clog2(LEDS_DRIVEN) : 1;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] cnt_q;
  logic [AW:0]   cnt_next;
  logic [LW-1:0] rd_idx_q;
  logic [31:0]   start_tick_q;
  logic [31:0]   elapsed;

  assign cnt_next = {1'b0, cnt_q} + {{AW{1'b0}}, 1'b1};
  assign elapsed  = now_tick_i - start_tick_q;

  assign sts_o.is_sync1     = (rx_byte_i == SYNC1_BYTE);
  assign sts_o.is_sync2     = (rx_byte_i == SYNC2_BYTE);
  assign sts_o.addr_match   = (rx_byte_i == board_addr_i);
  assign sts_o.is_cmd       = (rx_byte_i == CMD_BYTE);
  assign sts_o.is_trail1    = (rx_byte_i == TRAIL1_BYTE);
  assign sts_o.is_trail2    = (rx_byte_i == TRAIL2_BYTE);
  assign sts_o.timeout      = (rx_timeout_i != 32'd0) && (elapsed >= rx_timeout_i);
  assign sts_o.payload_last = (cnt_next >= (AW+1)'(PAYLOAD_BYTES));
  assign sts_o.rd_last      = (rd_idx_q == LW'(LEDS_DRIVEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      rd_idx_q     <= '0;
      start_tick_q <= '0;
    end else begin
      if (cmd_i.rec_tick) start_tick_q <= now_tick_i;
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.wr_byte) begin
        cnt_q <= cnt_next[AW-1:0];
      end
      if (cmd_i.rd_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_next) begin
        rd_idx_q <= rd_idx_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) mem[cnt_q] <= rx_byte_i;
    if (cmd_i.rd_issue) rd_data_q <= mem[AW'(rd_idx_q)];
  end

  assign led_index_o     = LED_IDX_W'(rd_idx_q);
  assign led_state_o     = rd_data_q;
  assign last_of_frame_o = sts_o.rd_last;

endmodule
